// File: src/figi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// figi_pkg
// Shared types, constants and character helpers for the FIGI check digit
// validator.
// ----------------------------------------------------------------------------
package figi_pkg;

   localparam logic [3:0] FIGI_LEN  = 4'd12;
   localparam logic [3:0] CHECK_POS = 4'd11;
   localparam logic [3:0] POS_G     = 4'd2;

   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_B = 8'h42;
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_I = 8'h49;
   localparam logic [7:0] CHAR_O = 8'h4F;
   localparam logic [7:0] CHAR_U = 8'h55;
   localparam logic [7:0] CHAR_Z = 8'h5A;

   localparam logic [5:0] LETTER_BASE = 6'd10;

   typedef struct packed {
      logic       ok;
      logic [5:0] val;   // 0..35
   } char_map_type;

   // digit or allowed consonant to its value
   function automatic char_map_type map_char(input logic [7:0] c);
      char_map_type m;
      m.ok  = 1'b0;
      m.val = 6'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         m.ok  = 1'b1;
         m.val = 6'(c - CHAR_0);
      end else if (c >= CHAR_B && c <= CHAR_Z && c != CHAR_E && c != CHAR_I &&
                   c != CHAR_O && c != CHAR_U) begin
         m.ok  = 1'b1;
         m.val = LETTER_BASE + 6'(c - CHAR_A);
      end
      return m;
   endfunction

   // tens plus units of a value up to 70
   function automatic logic [3:0] digit_sum(input logic [6:0] v);
      logic [2:0] tens;
      logic [6:0] units;
      if (v >= 7'd70)      tens = 3'd7;
      else if (v >= 7'd60) tens = 3'd6;
      else if (v >= 7'd50) tens = 3'd5;
      else if (v >= 7'd40) tens = 3'd4;
      else if (v >= 7'd30) tens = 3'd3;
      else if (v >= 7'd20) tens = 3'd2;
      else if (v >= 7'd10) tens = 3'd1;
      else                 tens = 3'd0;
      units = v - 7'(tens) * 7'd10;
      return 4'(tens) + units[3:0];
   endfunction

   // reduce a value up to 29 modulo 10
   function automatic logic [3:0] mod_ten(input logic [4:0] s);
      logic [4:0] r;
      if (s >= 5'd20)      r = s - 5'd20;
      else if (s >= 5'd10) r = s - 5'd10;
      else                 r = s;
      return r[3:0];
   endfunction

endpackage

// File: src/figi_check_digit_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// figi_check_digit_validator_top
// Streams a candidate FIGI one byte per transfer and reports on the last
// byte whether the prefix, character set, length and check digit are valid.
// ----------------------------------------------------------------------------
//   channel | direction | payload                   | handshake
//   req     | in        | req_ch[7:0], req_is_last  | req_valid / req_ready
//   rsp     | out       | rsp_valid_res             | rsp_valid / rsp_ready
//
// One byte per cycle while req_ready is high: map, double, digit sum and
// mod-10 add are combinational and settle into the state registers; the verdict
// lands in the output register on the cycle after the last byte.
// Reset clears position, sum, failure flag and the output valid.
// req_ready drops only while a verdict waits in the output register and
// rsp_ready is low.
// ----------------------------------------------------------------------------
module figi_check_digit_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res
);

   logic [3:0] position_ff, position_in;
   logic [3:0] sum_ff, sum_in;
   logic       failed_ff, failed_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_res_ff, rsp_res_in;

   logic                  req_xfer;
   figi_pkg::char_map_type cmap;
   logic                  prefix_ok;
   logic [6:0]            weighted;
   logic [3:0]            contrib;
   logic [3:0]            next_pos;
   logic [3:0]            next_sum;
   logic                  next_failed;
   logic                  verdict;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      cmap = figi_pkg::map_char(req_ch);
      if (position_ff == 4'd0 || position_ff == 4'd1) prefix_ok = (req_ch == figi_pkg::CHAR_B);
      else if (position_ff == figi_pkg::POS_G)        prefix_ok = (req_ch == figi_pkg::CHAR_G);
      else                                            prefix_ok = 1'b1;

      // odd positions are doubled
      weighted = position_ff[0] ? {cmap.val, 1'b0} : {1'b0, cmap.val};
      contrib  = figi_pkg::digit_sum(weighted);

      next_sum    = sum_ff;
      next_failed = failed_ff;
      if (position_ff < figi_pkg::CHECK_POS) begin
         if (!prefix_ok || !cmap.ok) next_failed = 1'b1;
         else next_sum = figi_pkg::mod_ten(5'(sum_ff) + 5'(contrib));
      end else if (position_ff == figi_pkg::CHECK_POS) begin
         if (req_ch >= figi_pkg::CHAR_0 && req_ch <= figi_pkg::CHAR_9)
            next_sum = figi_pkg::mod_ten(5'(sum_ff) + 5'(req_ch[3:0]));
         else
            next_failed = 1'b1;
      end

      next_pos = (position_ff < figi_pkg::FIGI_LEN) ? position_ff + 4'd1 : position_ff;
      verdict  = (next_pos >= figi_pkg::FIGI_LEN) && !next_failed && (next_sum == 4'd0);
   end

   always_comb begin
      position_in  = position_ff;
      sum_in       = sum_ff;
      failed_in    = failed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_res_in   = rsp_res_ff;
      if (req_xfer) begin
         if (req_is_last) begin
            position_in  = 4'd0;
            sum_in       = 4'd0;
            failed_in    = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_res_in   = verdict;
         end else begin
            position_in = next_pos;
            sum_in      = next_sum;
            failed_in   = next_failed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= 4'd0;
         sum_ff       <= 4'd0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         sum_ff       <= sum_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= 4'd9)
      else $error("running sum left 0..9");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      position_ff <= figi_pkg::FIGI_LEN)
      else $error("position beyond saturation");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_is_last |=> rsp_valid)
      else $error("last byte produced no verdict");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_is_last |=> position_ff == 4'd0 && sum_ff == 4'd0 && !failed_ff)
      else $error("state not cleared after last byte");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty output register");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams candidate identifiers through the FIGI check digit validator. A
// local model tracks position, mod-10 sum and the failure flag per byte and
// queues the verdict expected for each last byte. Random sender gaps are
// applied on the request channel and backpressure on the response channel.
// ----------------------------------------------------------------------------
module tb;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch      = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b1;
   logic       rsp_valid_res;

   figi_check_digit_validator_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state
   logic [3:0]  fig_pos  = '0;
   int unsigned fig_sum  = 0;
   bit          fig_fail = 1'b0;
   bit          expected_verdicts[$];

   // candidate under construction
   logic [7:0] code_buf [0:17];
   int         code_len;
   string      figi_alphabet = "0123456789BCDFGHJKLMNPQRSTVWXYZ";

   bit idle_on    = 1'b0;
   int stall_left = 0;
   int errors     = 0;
   int chars_sent = 0;
   int n_valid    = 0;
   int n_invalid  = 0;
   bit want;

   function automatic bit is_digit(input logic [7:0] c);
      return c inside {[figi_pkg::CHAR_0:figi_pkg::CHAR_9]};
   endfunction

   function automatic bit allowed_char(input logic [7:0] c);
      if (is_digit(c))
         return 1'b1;
      return c inside {[figi_pkg::CHAR_B:figi_pkg::CHAR_Z]} &&
             !(c inside {figi_pkg::CHAR_E, figi_pkg::CHAR_I,
                         figi_pkg::CHAR_O, figi_pkg::CHAR_U});
   endfunction

   // digit-sum contribution of an allowed character at positions 0..10
   function automatic int unsigned char_weight(input logic [7:0] c, input int pos);
      int unsigned v;
      v = is_digit(c) ? int'(c) - int'(figi_pkg::CHAR_0)
                      : int'(c) - int'(figi_pkg::CHAR_A) + 10;
      if (pos % 2 == 1)
         v = v * 2;
      return v / 10 + v % 10;
   endfunction

   function automatic void advance_figi(input logic [7:0] c, input bit last);
      bit ok;
      ok = 1'b1;
      if (fig_pos < figi_pkg::CHECK_POS) begin
         if (fig_pos < figi_pkg::POS_G)
            ok = (c == figi_pkg::CHAR_B);
         else if (fig_pos == figi_pkg::POS_G)
            ok = (c == figi_pkg::CHAR_G);
         if (!ok || !allowed_char(c))
            fig_fail = 1'b1;
         else
            fig_sum = (fig_sum + char_weight(c, int'(fig_pos))) % 10;
      end else if (fig_pos == figi_pkg::CHECK_POS) begin
         if (is_digit(c))
            fig_sum = (fig_sum + int'(c) - int'(figi_pkg::CHAR_0)) % 10;
         else
            fig_fail = 1'b1;
      end
      if (fig_pos < figi_pkg::FIGI_LEN)
         fig_pos = fig_pos + 4'd1;
      if (last) begin
         expected_verdicts.push_back(fig_pos >= figi_pkg::FIGI_LEN && !fig_fail &&
                                     fig_sum == 0);
         fig_pos  = '0;
         fig_sum  = 0;
         fig_fail = 1'b0;
      end
   endfunction

   // well-formed code with matching check digit; fill of zero means random body
   function automatic void make_valid_figi(input logic [7:0] fill);
      int unsigned s;
      s = 0;
      code_buf[0] = figi_pkg::CHAR_B;
      code_buf[1] = figi_pkg::CHAR_B;
      code_buf[2] = figi_pkg::CHAR_G;
      for (int i = 3; i < 11; i++)
         code_buf[i] = (fill != 8'h00) ? fill : figi_alphabet[$urandom_range(0, 30)];
      for (int i = 0; i < 11; i++)
         s += char_weight(code_buf[i], i);
      code_buf[11] = figi_pkg::CHAR_0 + 8'((10 - s % 10) % 10);
      code_len = 12;
   endfunction

   function automatic void set_code(input string s);
      for (int i = 0; i < s.len(); i++)
         code_buf[i] = s[i];
      code_len = s.len();
   endfunction

   task automatic send_char(input logic [7:0] c, input bit last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_ch      <= c;
      req_is_last <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      advance_figi(c, last);
      chars_sent++;
   endtask

   task automatic send_code();
      for (int i = 0; i < code_len; i++)
         send_char(code_buf[i], i == code_len - 1);
   endtask

   task automatic test_well_formed_codes();
      make_valid_figi(figi_pkg::CHAR_0);
      send_code();
      make_valid_figi(figi_pkg::CHAR_Z);
      send_code();
      // wrong check digit
      make_valid_figi(figi_pkg::CHAR_Z);
      code_buf[11] = figi_pkg::CHAR_0 +
                     8'((int'(code_buf[11]) - int'(figi_pkg::CHAR_0) + 1) % 10);
      send_code();
      // trailing bytes past the check digit are ignored
      make_valid_figi(figi_pkg::CHAR_9);
      code_buf[12] = 8'hFF;
      code_buf[13] = 8'h00;
      code_buf[14] = figi_pkg::CHAR_A;
      code_len = 15;
      send_code();
   endtask

   task automatic test_prefix_and_charset();
      set_code("A");    send_code();
      set_code("BC");   send_code();
      set_code("BBH");  send_code();
      set_code("BBGE"); send_code();
      set_code("BBGa"); send_code();
      set_code("BBG/"); send_code();
      set_code("BBG:"); send_code();
      set_code("BBG@"); send_code();
      set_code("BBG["); send_code();
      set_code("BBG?");
      code_buf[3] = 8'h80;
      send_code();
      set_code("?");
      code_buf[0] = 8'hFF;
      send_code();
      // letter in the check digit slot
      make_valid_figi(8'h00);
      code_buf[11] = figi_pkg::CHAR_B;
      send_code();
      // vowel mid-body, rest of the code still streams in
      make_valid_figi(8'h00);
      code_buf[5] = figi_pkg::CHAR_U;
      send_code();
   endtask

   task automatic test_length_rules();
      set_code("B");
      send_code();
      set_code("BBG");
      send_code();
      make_valid_figi(8'h00);
      code_len = 11;
      send_code();
   endtask

   task automatic test_random_stream();
      int sent;
      int kind;
      int extra;
      sent = 0;
      while (sent < 480) begin
         idle_on = (sent < 380) ? ($urandom_range(0, 4) != 0) : 1'b0;
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            make_valid_figi(8'h00);
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            for (int i = 0; i < extra; i++)
               code_buf[12 + i] = 8'($urandom_range(0, 255));
            code_len = 12 + extra;
         end else if (kind < 70) begin
            make_valid_figi(8'h00);
            code_buf[$urandom_range(0, 11)] = 8'($urandom_range(0, 255));
         end else if (kind < 80) begin
            make_valid_figi(8'h00);
            code_len = $urandom_range(1, 11);
         end else begin
            code_len = $urandom_range(1, 16);
            for (int i = 0; i < code_len; i++)
               code_buf[i] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
               set_code("BBG");
            if (code_len < 3)
               code_len = $urandom_range(1, 16);
         end
         send_code();
         sent += code_len;
      end
   endtask

   // receiver backpressure in bursts
   always @(posedge clock) begin
      if (stall_left == 0 && idle_on && !reset && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 16);
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // handshake signals are stable at the falling edge; a transfer follows at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected verdict: valid_res actual %0b", rsp_valid_res);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_valid_res !== want) begin
               $error("valid_res mismatch: expected %0b, actual %0b", want, rsp_valid_res);
               errors++;
            end
            if (want)
               n_valid++;
            else
               n_invalid++;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;
      test_well_formed_codes();
      test_prefix_and_charset();
      test_length_rules();
      test_random_stream();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d bytes streamed, %0d verdicts checked (%0d valid, %0d rejected)",
               chars_sent, n_valid + n_invalid, n_valid, n_invalid);
      $display("covered prefix, charset, length, trailing bytes and check digit rules");
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d verdicts outstanding", expected_verdicts.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
src/figi_pkg.sv
src/figi_check_digit_validator_top.sv
tb/tb.sv
